>>> hw/rtl/bed_pkg.sv
// ----------------------------------------------------------------------------
// bed_pkg
// Types and constants shared by the brace escape deframer.
// ----------------------------------------------------------------------------
package bed_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 255;

  localparam logic [7:0] OPEN_BRACE  = 8'h7B;
  localparam logic [7:0] CLOSE_BRACE = 8'h7D;
  localparam logic [7:0] ESCAPE_MARK = 8'h25;

  typedef enum logic [1:0] {
    PH_AWAIT  = 2'd0,
    PH_FRAME  = 2'd1,
    PH_ESCAPE = 2'd2,
    PH_IGNORE = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_DATA      = 3'd0,
    ST_END       = 3'd1,
    ST_BAD_START = 3'd2,
    ST_NO_CLOSE  = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_t;

  // One decoded result, as produced by the decode logic for one byte.
  typedef struct packed {
    logic       valid;
    status_t    status;
    logic [7:0] data;
    logic [7:0] length;
  } bed_res_t;

endpackage

>>> hw/rtl/bed_if.sv
// ----------------------------------------------------------------------------
// bed_in_if / bed_out_if
// Valid/ready channels for raw buffer bytes and decoded results.
// ----------------------------------------------------------------------------
interface bed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       buffer_end;

  modport source (output valid, output in_byte, output buffer_end, input ready);
  modport sink   (input valid, input in_byte, input buffer_end, output ready);
endinterface

interface bed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic [7:0] frame_length;

  modport source (output valid, output out_byte, output status, output frame_length,
                  input ready);
  modport sink   (input valid, input out_byte, input status, input frame_length,
                  output ready);
endinterface

>>> hw/rtl/bed_decode.sv
// ----------------------------------------------------------------------------
// bed_decode
// Next phase, data count and result for one raw byte.
// ----------------------------------------------------------------------------
module bed_decode #(
  parameter int unsigned MAX_FRAME_BYTES = bed_pkg::MAX_FRAME_BYTES_DEF,
  parameter int unsigned CNT_W           = 8
) (
  input  bed_pkg::phase_t   phase,
  input  logic [CNT_W-1:0]  count,
  input  logic [7:0]        data_byte,
  input  logic              last,
  output bed_pkg::bed_res_t res,
  output bed_pkg::phase_t   phase_nxt,
  output logic [CNT_W-1:0]  count_nxt
);
  import bed_pkg::*;

  // data byte handling, shared by in-frame and escaped bytes
  bed_res_t         td_res;
  phase_t           td_phase;
  logic [CNT_W-1:0] td_count;
  logic             at_limit;

  assign at_limit = (count >= CNT_W'(MAX_FRAME_BYTES));

  always_comb begin
    td_res   = '{valid: 1'b1, status: ST_DATA, data: 8'd0, length: 8'd0};
    td_phase = phase;
    td_count = count;
    if (at_limit) begin
      td_res.status = ST_TOO_LONG;
      td_phase      = PH_IGNORE;
    end else if (last) begin
      td_res.status = ST_NO_CLOSE;
    end else begin
      td_res.data = data_byte;
      td_count    = count + CNT_W'(1);
      td_phase    = PH_FRAME;
    end
  end

  always_comb begin
    res       = '{valid: 1'b0, status: ST_DATA, data: 8'd0, length: 8'd0};
    phase_nxt = phase;
    count_nxt = count;
    case (phase)
      PH_AWAIT: begin
        if (data_byte == OPEN_BRACE) begin
          count_nxt = '0;
          phase_nxt = PH_FRAME;
          if (last) begin
            res.valid  = 1'b1;
            res.status = ST_NO_CLOSE;
          end
        end else begin
          phase_nxt  = PH_IGNORE;
          res.valid  = 1'b1;
          res.status = ST_BAD_START;
        end
      end
      PH_FRAME: begin
        if (data_byte == ESCAPE_MARK) begin
          phase_nxt = PH_ESCAPE;
          if (last) begin
            res.valid  = 1'b1;
            res.status = ST_NO_CLOSE;
          end
        end else if (data_byte == CLOSE_BRACE) begin
          phase_nxt  = PH_IGNORE;
          res.valid  = 1'b1;
          res.status = ST_END;
          res.length = 8'(count);
        end else begin
          res       = td_res;
          phase_nxt = td_phase;
          count_nxt = td_count;
        end
      end
      PH_ESCAPE: begin
        res       = td_res;
        phase_nxt = td_phase;
        count_nxt = td_count;
      end
      default: ;
    endcase
    // every buffer starts afresh
    if (last) begin
      phase_nxt = PH_AWAIT;
      count_nxt = '0;
    end
  end

endmodule

>>> hw/rtl/brace_escape_deframer_unit.sv
// ----------------------------------------------------------------------------
// brace_escape_deframer_unit
// Brace framed, percent escaped byte stream deframer.
// ----------------------------------------------------------------------------
// Takes one raw byte per cycle, sustained, and returns at most one result per
// byte: an unescaped data byte, a frame end with the data length, or an error
// (bad start, no closing brace, too long). Bytes pass an input register, then
// the decode logic, which holds the phase and data count, then a result
// register, from which each result is offered on the output. The update of
// phase and count in the decode stage sets the rate; a stall on the result
// side stops both stages, and the block keeps taking bytes while the input
// register is empty. On any error the receiver drops the data of the current
// frame. Frame lengths above 255 report their low 8 bits.
module brace_escape_deframer_unit #(
  parameter int unsigned MAX_FRAME_BYTES = bed_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bed_in_if.sink      in_chan,
  bed_out_if.source   out_chan
);
  import bed_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // decode state
  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // result register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  status_t    out_status_r;
  logic [7:0] out_len_r;

  bed_res_t res;
  logic     s1_adv;
  logic     in_take;

  assign s1_adv  = !out_valid_r || out_chan.ready;
  assign in_take = in_chan.valid && in_chan.ready;

  assign in_chan.ready = !s1_valid_r || s1_adv;

  bed_decode #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .CNT_W          (CNT_W)
  ) u_decode (
    .phase    (phase_r),
    .count    (count_r),
    .data_byte(s1_byte_r),
    .last     (s1_last_r),
    .res      (res),
    .phase_nxt(phase_nxt),
    .count_nxt(count_nxt)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = s1_valid_r && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_AWAIT;
      count_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_valid_r && s1_adv) begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_chan.in_byte;
      s1_last_r <= in_chan.buffer_end;
    end
    if (s1_adv && s1_valid_r) begin
      out_byte_r   <= res.data;
      out_status_r <= res.status;
      out_len_r    <= res.length;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.out_byte     = out_byte_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.frame_length = out_len_r;

  // a buffer's last byte always leaves the decoder ready for a new buffer
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_adv && s1_last_r |=> phase_r == PH_AWAIT && count_r == '0)
    else $error("state not cleared after buffer end");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_FRAME_BYTES))
    else $error("data count above frame limit");

  a_ignore_silent: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_adv && phase_r == PH_IGNORE |=> !out_valid_r)
    else $error("result produced while ignoring bytes");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_chan.ready)
    else $error("input stalled with empty result register");

  a_len_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_END |-> out_len_r == 8'd0)
    else $error("frame length set outside frame end");

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for brace_escape_deframer_unit.
// ----------------------------------------------------------------------------
// Sends whole receive buffers over the byte channel with random gaps. A
// behavioral copy of the deframer predicts the result of each accepted byte.
// Results are checked in order as they leave the block under random
// back-pressure. The stimulus is directed corner buffers first, then mostly
// well-formed frames with random content, plus truncated, bad-start and
// noise buffers, and two frames at the length limit.
// ----------------------------------------------------------------------------
import bed_pkg::*;

typedef struct packed {
  logic [7:0] data;
  status_t    status;
  logic [7:0] length;
} deframe_result_t;

class deframer_scoreboard;
  phase_t          phase;
  int unsigned     data_count;
  deframe_result_t expected_q[$];
  int              mismatches;
  int              status_seen[5];

  function new();
    phase      = PH_AWAIT;
    data_count = 0;
    mismatches = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
  endfunction

  // Data byte inside a frame: length bound wins over the buffer end.
  function void take_data(logic [7:0] b, logic last, output deframe_result_t r);
    r.data   = 8'h00;
    r.status = ST_DATA;
    r.length = 8'h00;
    if (data_count >= MAX_FRAME_BYTES_DEF) begin
      phase    = PH_IGNORE;
      r.status = ST_TOO_LONG;
    end else if (last) begin
      r.status = ST_NO_CLOSE;
    end else begin
      data_count++;
      phase  = PH_FRAME;
      r.data = b;
    end
  endfunction

  function void note_byte(logic [7:0] b, logic last);
    deframe_result_t r;
    bit              produced;
    produced = 1'b0;
    r.data   = 8'h00;
    r.status = ST_DATA;
    r.length = 8'h00;
    case (phase)
      PH_AWAIT: begin
        if (b == OPEN_BRACE) begin
          data_count = 0;
          phase      = PH_FRAME;
          if (last) begin
            produced = 1'b1;
            r.status = ST_NO_CLOSE;
          end
        end else begin
          phase    = PH_IGNORE;
          produced = 1'b1;
          r.status = ST_BAD_START;
        end
      end
      PH_FRAME: begin
        if (b == ESCAPE_MARK) begin
          phase = PH_ESCAPE;
          if (last) begin
            produced = 1'b1;
            r.status = ST_NO_CLOSE;
          end
        end else if (b == CLOSE_BRACE) begin
          phase    = PH_IGNORE;
          produced = 1'b1;
          r.status = ST_END;
          r.length = data_count[7:0];
        end else begin
          take_data(b, last, r);
          produced = 1'b1;
        end
      end
      PH_ESCAPE: begin
        take_data(b, last, r);
        produced = 1'b1;
      end
      default: ;
    endcase
    if (last) begin
      phase      = PH_AWAIT;
      data_count = 0;
    end
    if (produced) expected_q.push_back(r);
  endfunction

  function void check_result(logic [7:0] b, logic [2:0] st, logic [7:0] len);
    deframe_result_t e;
    if (st <= 3'd4) status_seen[st]++;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected result byte %02h status %0d length %0d", b, st, len);
      return;
    end
    e = expected_q.pop_front();
    if (b !== e.data || st !== e.status || len !== e.length) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: expected byte %02h status %0d length %0d, got %02h %0d %0d",
                 e.data, e.status, e.length, b, st, len);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function int failures();
    return mismatches + expected_q.size();
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1100;

  logic clk;
  logic rst_n;

  bed_in_if  in_if ();
  bed_out_if out_if ();

  brace_escape_deframer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  deframer_scoreboard sb;
  int unsigned        cycle_count = 0;
  int unsigned        bytes_sent = 0;
  int unsigned        buffers_sent = 0;
  bit                 in_idle_on = 1'b1;
  bit                 out_idle_on = 1'b1;
  logic [7:0]         buf_q[$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("ERROR: timed out after %0d cycles", cycle_count);
    $display("** brace_escape_deframer_unit: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.out_byte, out_if.status, out_if.frame_length);
  end

  // Result side: random stall before each transaction, with stall-free stretches.
  initial begin
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      int gap;
      gap = out_idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      if ($urandom_range(0, 39) == 0) out_idle_on = !out_idle_on;
      @(negedge clk);
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.in_byte    <= b;
    in_if.buffer_end <= last;
    do @(posedge clk); while (!in_if.ready);
    sb.note_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_buffer();
    in_idle_on = ($urandom_range(0, 3) != 0);
    foreach (buf_q[i]) send_byte(buf_q[i], i == buf_q.size() - 1);
    buffers_sent++;
  endtask

  // Biased toward the three framing characters.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return OPEN_BRACE;
      1: return CLOSE_BRACE;
      2: return ESCAPE_MARK;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Close brace and percent must be escaped; others are escaped now and then.
  function automatic void push_payload(logic [7:0] b);
    if (b == CLOSE_BRACE || b == ESCAPE_MARK || $urandom_range(0, 7) == 0)
      buf_q.push_back(ESCAPE_MARK);
    buf_q.push_back(b);
  endfunction

  function automatic void build_frame(int n);
    buf_q.delete();
    buf_q.push_back(OPEN_BRACE);
    repeat (n) push_payload(pick_byte());
    buf_q.push_back(CLOSE_BRACE);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CLOSE_BRACE || b == ESCAPE_MARK) b = 8'h00;
    return b;
  endfunction

  initial begin
    int kind;
    int len;
    int cut;
    int long_done;
    logic [7:0] first;

    sb               = new();
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.in_byte    = 8'h00;
    in_if.buffer_end = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty frame, escapes and extremes, bad starts, early ends.
    buf_q = '{OPEN_BRACE, CLOSE_BRACE};
    send_buffer();
    buf_q = '{OPEN_BRACE, 8'h00, 8'hFF, ESCAPE_MARK, CLOSE_BRACE, ESCAPE_MARK,
              ESCAPE_MARK, OPEN_BRACE, CLOSE_BRACE, 8'h41};
    send_buffer();
    buf_q = '{8'h41, OPEN_BRACE};
    send_buffer();
    buf_q = '{OPEN_BRACE};
    send_buffer();
    buf_q = '{OPEN_BRACE, 8'h55};
    send_buffer();
    buf_q = '{OPEN_BRACE, ESCAPE_MARK};
    send_buffer();
    buf_q = '{OPEN_BRACE, ESCAPE_MARK, CLOSE_BRACE};
    send_buffer();
    buf_q = '{CLOSE_BRACE};
    send_buffer();

    long_done = 0;
    while (bytes_sent < RANDOM_ITEMS) begin
      if (long_done < 2 && bytes_sent >= 300 + 350 * long_done) begin
        // Frames at the length limit: a full one, then one byte too many.
        buf_q.delete();
        buf_q.push_back(OPEN_BRACE);
        repeat (MAX_FRAME_BYTES_DEF) push_payload(pick_byte());
        if (long_done == 0) begin
          buf_q.push_back(CLOSE_BRACE);
          if ($urandom_range(0, 1) == 1) buf_q.push_back(pick_byte());
        end else begin
          case ($urandom_range(0, 2))
            0: begin
              buf_q.push_back(plain_byte());
              buf_q.push_back(pick_byte());
            end
            1: buf_q.push_back(plain_byte());
            default: begin
              buf_q.push_back(ESCAPE_MARK);
              buf_q.push_back(pick_byte());
            end
          endcase
        end
        long_done++;
      end else begin
        kind = $urandom_range(0, 99);
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        if (kind < 70) begin
          build_frame(len);
          if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) buf_q.push_back(pick_byte());
        end else if (kind < 82) begin
          // truncated before the closing brace, possibly mid-escape
          build_frame(len);
          cut = $urandom_range(1, buf_q.size() - 1);
          while (buf_q.size() > cut) void'(buf_q.pop_back());
        end else if (kind < 91) begin
          first = 8'($urandom_range(0, 255));
          if (first == OPEN_BRACE) first = CLOSE_BRACE;
          buf_q = '{first};
          repeat ($urandom_range(0, 4)) buf_q.push_back(pick_byte());
        end else begin
          buf_q.delete();
          repeat ($urandom_range(1, 8)) buf_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      send_buffer();
    end
    in_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes in %0d buffers, including two frames at the length limit.",
             bytes_sent, buffers_sent);
    $display("Results: %0d data, %0d frame ends, %0d bad starts, %0d unclosed, %0d too long.",
             sb.status_seen[ST_DATA], sb.status_seen[ST_END], sb.status_seen[ST_BAD_START],
             sb.status_seen[ST_NO_CLOSE], sb.status_seen[ST_TOO_LONG]);
    if (sb.failures() == 0) begin
      $display("** brace_escape_deframer_unit: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
      $display("** brace_escape_deframer_unit: FAILED **");
    end
    $finish;
  end
endmodule
